// ===== rtl/prp_pkg.sv =====
// Shared types and constants for the pixel row packer.
// Used by the front end, the entry queue, the byte emitter and the top level.
`default_nettype none

package prp_pkg;

   // Packing modes held in the mode register.
   localparam logic [1:0] MODE_BIT1  = 2'd0;
   localparam logic [1:0] MODE_NIB4  = 2'd1;
   localparam logic [1:0] MODE_BYTE8 = 2'd2;
   localparam logic [1:0] MODE_WORD16 = 2'd3;

   localparam logic [1:0] MODE_RESET = MODE_BYTE8;

   // Default number of entries in the queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One queued job: either a single byte in data[7:0], or a 16-bit sample
   // that leaves as two beats, low byte first.
   typedef struct packed {
      logic [15:0] data;
      logic        two_beats;
      logic        row_end;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/prp_front.sv =====
// Front end of the pixel row packer: accepts samples, packs sub-byte modes
// into the accumulator and pushes finished jobs. Depends on prp_pkg.
`default_nettype none

module prp_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_wr_en,
   input  wire  [1:0]        csr_wr_data,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire  [15:0]       req_sample,
   input  wire               req_row_end,
   input  wire               queue_full,
   output logic              push,
   output prp_pkg::entry_type push_entry
);
   import prp_pkg::*;

   logic [1:0] mode_ff, mode_in;
   logic [7:0] acc_ff, acc_in;
   logic [2:0] fill_ff, fill_in;
   logic       accept;
   logic       emit;
   logic [7:0] acc_next;

   // A sample is taken whenever the queue has room for its job.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Merge the sample into the byte and decide whether a job comes out.
   always_comb begin
      acc_next = acc_ff;
      emit     = 1'b1;
      push_entry.data      = {8'd0, req_sample[7:0]};
      push_entry.two_beats = 1'b0;
      push_entry.row_end   = req_row_end;
      case (mode_ff)
         MODE_BIT1: begin
            acc_next = acc_ff | ({7'd0, req_sample[0]} << (3'd7 - fill_ff));
            emit     = (fill_ff == 3'd7) || req_row_end;
            push_entry.data = {8'd0, acc_next};
         end
         MODE_NIB4: begin
            acc_next = acc_ff | (fill_ff[0] ? {4'd0, req_sample[3:0]}
                                            : {req_sample[3:0], 4'd0});
            emit     = fill_ff[0] || req_row_end;
            push_entry.data = {8'd0, acc_next};
         end
         MODE_BYTE8: begin
            emit = 1'b1;
         end
         default: begin
            push_entry.data      = req_sample;
            push_entry.two_beats = 1'b1;
         end
      endcase
   end

   assign push = accept && emit;

   // Next state of the mode register and the accumulator.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      fill_in = fill_ff;
      if (csr_wr_en) begin
         mode_in = csr_wr_data;
         acc_in  = 8'd0;
         fill_in = 3'd0;
      end else if (accept) begin
         if (emit) begin
            acc_in  = 8'd0;
            fill_in = 3'd0;
         end else begin
            acc_in  = acc_next;
            fill_in = fill_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         acc_ff  <= 8'd0;
         fill_ff <= 3'd0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/prp_queue.sv =====
// Short job queue between the front end and the byte emitter.
// Depends on prp_pkg; depth must be a power of two, at least two.
`default_nettype none

module prp_queue #(
   parameter int QueueDepth = prp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  prp_pkg::entry_type push_entry,
   output logic               full,
   input  wire                pop,
   output logic               not_empty,
   output prp_pkg::entry_type head_entry
);
   import prp_pkg::*;

   localparam int AddrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountW = $clog2(QueueDepth + 1);

   entry_type         slot_ff [QueueDepth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CountW'(QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   // Pointers wrap on their own since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AddrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + AddrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; an entry is only read after it was written.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/prp_back.sv =====
// Byte emitter of the pixel row packer: turns queued jobs into output
// beats held in an output register. Depends on prp_pkg.
`default_nettype none

module prp_back (
   input  wire                clock,
   input  wire                reset,
   input  wire                not_empty,
   input  prp_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_row_last,
   output logic               rsp_run_last
);
   import prp_pkg::*;

   logic       valid_ff, valid_in;
   logic       high_ff, high_in;
   logic [7:0] byte_ff, byte_in;
   logic       row_last_ff, row_last_in;
   logic       run_last_ff, run_last_in;
   logic       load;

   // The output register takes a new beat when empty or being drained.
   assign load = not_empty && (!valid_ff || rsp_ready);

   // Pick the next beat from the head job; a two-beat job stays queued
   // until its high byte has been loaded into the output register.
   always_comb begin
      valid_in    = valid_ff && !rsp_ready;
      high_in     = high_ff;
      byte_in     = byte_ff;
      row_last_in = row_last_ff;
      run_last_in = run_last_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (high_ff) begin
            byte_in     = head_entry.data[15:8];
            row_last_in = head_entry.row_end;
            run_last_in = 1'b1;
            high_in     = 1'b0;
            pop         = 1'b1;
         end else begin
            byte_in     = head_entry.data[7:0];
            row_last_in = head_entry.row_end && !head_entry.two_beats;
            run_last_in = !head_entry.two_beats;
            high_in     = head_entry.two_beats;
            pop         = !head_entry.two_beats;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         high_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      row_last_ff <= row_last_in;
      run_last_ff <= run_last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_row_last = row_last_ff;
   assign rsp_run_last = run_last_ff;

endmodule

`default_nettype wire

// ===== rtl/pixel_row_packer_unit.sv =====
// Top level of the pixel row packer: front end, job queue and byte emitter.
// Depends on prp_pkg, prp_front, prp_queue and prp_back.
//
// Usage:
//   Samples enter on the req_ channel (valid/ready), one beat per sample,
//   with req_row_end marking the last sample of a raster row. Packed bytes
//   leave on the rsp_ channel, one beat per byte, with rsp_row_last on the
//   final byte of a row and rsp_run_last on the last byte a sample caused.
//   csr_wr_en/csr_wr_data write the packing mode (1-bit, 4-bit, 8-bit or
//   16-bit split); a write drops any partly filled byte. Write it only while
//   the block is idle.
//   A byte passes from the accepted sample completing it through the job
//   queue and then the output register before it is valid on rsp_.
//   Throughput: one sample per cycle in the sub-byte and 8-bit modes while
//   the queue has room; in 16-bit mode the output port carries one byte
//   per cycle while rsp_ready is high, so each sample leaves as two beats.
//   When the receiver stalls, the output register holds its beat and the
//   job queue (QueueDepth entries) absorbs further jobs; req_ready falls
//   only once the queue is full.
//   Reset (synchronous, active high) empties the queue and output register,
//   clears the accumulator and sets the mode to 8-bit pass-through.
`default_nettype none

module pixel_row_packer_unit #(
   parameter int QueueDepth = prp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_wr_data,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [15:0] req_sample,
   input  wire         req_row_end,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_row_last,
   output logic        rsp_run_last
);
   import prp_pkg::*;

   logic      push;
   logic      queue_full;
   logic      pop;
   logic      not_empty;
   entry_type push_entry;
   entry_type head_entry;

   // Front end: sample intake and sub-byte packing.
   prp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .req_row_end (req_row_end),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Job queue decoupling intake from output.
   prp_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_entry (head_entry)
   );

   // Byte emitter with its output register.
   prp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .not_empty    (not_empty),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_row_last (rsp_row_last),
      .rsp_run_last (rsp_run_last)
   );

endmodule

`default_nettype wire
